// ----- rtl/vlqp_pkg.sv -----
// Package for the length-prefixed field parser.
// Status codes and the per-byte result record shared by the parser core and the top level.
// No dependencies.
package vlqp_pkg;

	typedef enum logic [2:0] {
		ST_BUSY         = 3'd0,
		ST_OK           = 3'd1,
		ST_UNTERMINATED = 3'd2,
		ST_TOO_LONG     = 3'd3,
		ST_TRUNCATED    = 3'd4
	} status_t;

	localparam logic [7:0] PrefixMoreBit = 8'h80;
	localparam logic [7:0] PrefixDataMask = 8'h7F;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [15:0] bytes_read;
		status_t     field_status;
		logic        field_done;
	} result_t;

endpackage

// ----- rtl/vlqp_core.sv -----
// Parser state and per-byte step logic: prefix accumulation, limit check, payload count.
// Holds the max_string_length register. Depends on vlqp_pkg.
module vlqp_core #(
	parameter int LENGTH_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              end_of_packet,
	output vlqp_pkg::result_t result
);
	import vlqp_pkg::*;

	localparam logic [31:0] CountMask = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	typedef enum logic [1:0] {
		PHASE_PREFIX,
		PHASE_PAYLOAD
	} phase_t;

	phase_t                 phase_q;
	logic [31:0]            acc_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [LENGTH_BITS-1:0] cnt_q;
	logic [15:0]            max_q;

	phase_t                 phase_n;
	logic [31:0]            acc_n;
	logic [LENGTH_BITS-1:0] rem_n;
	logic [LENGTH_BITS-1:0] cnt_n;
	logic [31:0]            acc_shift;
	logic [31:0]            limit;
	logic [31:0]            max_ext;
	logic [LENGTH_BITS-1:0] cnt_inc;
	logic [LENGTH_BITS-1:0] rem_dec;

	assign acc_shift = {acc_q[24:0], data_byte[6:0] & PrefixDataMask[6:0]};
	assign max_ext   = {16'd0, max_q};
	assign limit     = (max_ext > CountMask) ? CountMask : max_ext;
	assign cnt_inc   = cnt_q + LENGTH_BITS'(1);
	assign rem_dec   = rem_q - LENGTH_BITS'(1);

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		rem_n   = rem_q;
		cnt_n   = cnt_q;
		result  = '{payload_valid: 1'b0, payload_byte: 8'd0, bytes_read: 16'd0,
			field_status: ST_BUSY, field_done: 1'b0};
		unique case (phase_q)
			PHASE_PAYLOAD: begin
				result.payload_valid = 1'b1;
				result.payload_byte  = data_byte;
				result.bytes_read    = 16'(cnt_inc);
				cnt_n = cnt_inc;
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					result.field_status = ST_OK;
					result.field_done   = 1'b1;
				end else if (end_of_packet) begin
					result.field_status = ST_TRUNCATED;
					result.field_done   = 1'b1;
				end
			end
			default: begin
				acc_n = acc_shift;
				if ((data_byte & PrefixMoreBit) != 8'd0) begin
					if (end_of_packet) begin
						result.field_status = ST_UNTERMINATED;
						result.field_done   = 1'b1;
					end
				end else begin
					priority if (acc_shift > limit) begin
						result.field_status = ST_TOO_LONG;
						result.field_done   = 1'b1;
					end else if (acc_shift == 32'd0) begin
						result.field_status = ST_OK;
						result.field_done   = 1'b1;
					end else if (end_of_packet) begin
						result.field_status = ST_TRUNCATED;
						result.field_done   = 1'b1;
					end else begin
						rem_n   = acc_shift[LENGTH_BITS-1:0];
						cnt_n   = '0;
						phase_n = PHASE_PAYLOAD;
					end
				end
			end
		endcase
		if (result.field_done) begin
			phase_n = PHASE_PREFIX;
			acc_n   = '0;
			rem_n   = '0;
			cnt_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_PREFIX;
			acc_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			max_q   <= 16'hFFFF;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (step) begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				rem_q   <= rem_n;
				cnt_q   <= cnt_n;
			end
		end
	end

`ifndef SYNTH
	a_prefix_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PHASE_PREFIX |-> (cnt_q == '0 && rem_q == '0))
		else $error("count state not clear during prefix");
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PHASE_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with nothing remaining");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.field_done) |=> (phase_q == PHASE_PREFIX && acc_q == 32'd0))
		else $error("parser not idle after field end");
`endif
endmodule

// ----- rtl/vlq_length_prefixed_field_parser.sv -----
// Top level of the length-prefixed field parser: stream handshake, input and result registers.
// Instantiates vlqp_core. Depends on vlqp_pkg.
//
//  channel  | direction | handshake          | contents
//  s_*      | in        | s_tvalid/s_tready  | tdata: data_byte; tlast: end_of_packet
//  m_*      | out       | m_tvalid/m_tready  | tdata: byte, bytes_read, status; tuser; tlast
//  cfg_*    | in        | cfg_we (no wait)   | max_string_length
//
// One byte per cycle sustained while m_tready is high; the accepting edge loads the input register,
// and when that byte steps the core its result loads the result register and is offered on m_*.
// The step logic is one shift, compare and count.
// Reset clears parser state and sets max_string_length to 65535.
// s_tready drops only while both registers hold a transaction and m_tready is low.
module vlq_length_prefixed_field_parser #(
	parameter int LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // max_string_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] data_byte
	input  logic        s_tlast,     // end_of_packet
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [7:0] payload_byte, [23:8] bytes_read,
	                                 // [26:24] field_status, [31:27] zero
	output logic        m_tuser,     // payload_valid
	output logic        m_tlast      // field_done
);
	import vlqp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       adv;
	result_t    res;
	result_t    res_s2;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	vlqp_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.step         (adv),
		.data_byte    (data_s1),
		.end_of_packet(last_s1),
		.result       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {5'd0, res_s2.field_status, res_s2.bytes_read, res_s2.payload_byte};
	assign m_tuser = res_s2.payload_valid;
	assign m_tlast = res_s2.field_done;

`ifndef SYNTH
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[26:24] == ST_BUSY) == !m_tlast))
		else $error("field_status and field_done disagree");
	a_prefix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[23:0] == 24'd0))
		else $error("non-payload transaction carries byte or count");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |=> (valid_s1 && $stable(data_s1)))
		else $error("input register lost a stalled transaction");
`endif
endmodule
